@@ src/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache engine.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam logic [10:0] MIN_PKT_LEN = 11'd28;
	localparam logic [15:0] OP_REQUEST  = 16'd1;

	localparam logic [31:0] OWN_IP_RST  = 32'h0A00_0001;
	localparam logic [31:0] GW_RST      = 32'h0A00_0002;
	localparam logic [31:0] MASK_RST    = 32'hFFFF_FF00;
	localparam logic [47:0] OWN_MAC_RST = 48'h5254_0012_3456;

	// register indexes
	localparam logic [1:0] REG_OWN_IP  = 2'd0;
	localparam logic [1:0] REG_GATEWAY = 2'd1;
	localparam logic [1:0] REG_MASK    = 2'd2;
	localparam logic [1:0] REG_OWN_MAC = 2'd3;

	typedef enum logic [1:0] {
		OP_RESOLVE,
		OP_LEARN,
		OP_DROP
	} op_t;

	// classified command from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] ip;      // next hop or sender ip
		logic [47:0] mac;
		logic [31:0] stamp;
		logic        reply;
	} cmd_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] mac_out;
		logic [31:0] hop_ip;
		logic        send_request;
		logic        send_reply;
		logic        dropped;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

endpackage

@@ src/arpc_if.sv @@
// ----------------------------------------------------------------------------
// arpc_in_if / arpc_out_if / arpc_cfg_if
// Valid/ready channels for the ARP cache engine.
// ----------------------------------------------------------------------------
interface arpc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] query_ip;
	logic [15:0] arp_opcode;
	logic [47:0] src_mac;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [10:0] pkt_len;
	logic [31:0] now_ticks;
	modport source (output valid, func, query_ip, arp_opcode, src_mac, src_ip,
		dst_ip, pkt_len, now_ticks, input ready);
	modport sink (input valid, func, query_ip, arp_opcode, src_mac, src_ip,
		dst_ip, pkt_len, now_ticks, output ready);
endinterface

interface arpc_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [47:0] mac_out;
	logic [31:0] hop_ip;
	logic        send_request;
	logic        send_reply;
	logic        dropped;
	modport source (output valid, hit, mac_out, hop_ip, send_request, send_reply,
		dropped, input ready);
	modport sink (input valid, hit, mac_out, hop_ip, send_request, send_reply,
		dropped, output ready);
endinterface

interface arpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/arpc_front.sv @@
// ----------------------------------------------------------------------------
// arpc_front
// Accepts input transactions, picks the next hop and classifies each item
// into a command for the back end. Two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module arpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	arpc_in_if.sink              in_ch,
	input  logic [31:0]          own_ip,
	input  logic [31:0]          gateway_addr,
	input  logic [31:0]          subnet_mask,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output arpc_pkg::cmd_t       cmd
);

	arpc_pkg::cmd_t cmd_new;
	arpc_pkg::cmd_t fifo_q [2];
	logic [1:0]     cnt_q;
	logic           rd_ptr_q, wr_ptr_q;
	logic           push, pop;

	// classify
	always_comb begin
		cmd_new       = '0;
		cmd_new.mac   = in_ch.src_mac;
		cmd_new.stamp = in_ch.now_ticks;
		if (!in_ch.func) begin
			cmd_new.op = arpc_pkg::OP_RESOLVE;
			cmd_new.ip = ((in_ch.query_ip & subnet_mask) != (own_ip & subnet_mask)) ?
				gateway_addr : in_ch.query_ip;
		end else if (in_ch.pkt_len < arpc_pkg::MIN_PKT_LEN) begin
			cmd_new.op = arpc_pkg::OP_DROP;
		end else begin
			cmd_new.op    = arpc_pkg::OP_LEARN;
			cmd_new.ip    = in_ch.src_ip;
			cmd_new.reply = (in_ch.arp_opcode == arpc_pkg::OP_REQUEST) &&
				(in_ch.dst_ip == own_ip);
		end
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != 2'd0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cmd_new;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ src/arpc_back.sv @@
// ----------------------------------------------------------------------------
// arpc_back
// Carries out commands against the cache: one entry examined per cycle for
// match, first free slot and oldest stamp, then write (learn) and result.
// ----------------------------------------------------------------------------
module arpc_back #(
	parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  arpc_pkg::cmd_t cmd,
	arpc_out_if.source     out_ch
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	arpc_pkg::state_t state_q, state_d;
	arpc_pkg::cmd_t   cmd_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0] ip_mem [ENTRIES];
	logic [47:0] mac_mem [ENTRIES];
	logic [31:0] stamp_mem [ENTRIES];

	logic [IW-1:0] rd_idx_q;
	logic          eval_s1, vld_s1;
	logic [31:0]   ip_s1, stamp_s1;
	logic [47:0]   mac_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q, free_q;
	logic [IW-1:0] match_q, slot_q;
	logic [31:0]   best_q;
	logic          best_set_q;
	arpc_pkg::res_t res_q;
	logic          cur_match, cur_free, cur_older, last_idx;
	logic [IW-1:0] wslot;

	assign cur_match = vld_s1 && (ip_s1 == cmd_q.ip);
	assign cur_free  = !vld_s1;
	assign cur_older = !best_set_q || (stamp_s1 < best_q);
	assign last_idx  = eval_s1 && (idx_s1 == LAST);
	assign wslot     = found_q ? match_q : slot_q;

	// next state
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) state_d = (cmd.op == arpc_pkg::OP_DROP) ?
					arpc_pkg::ST_OUT : arpc_pkg::ST_SCAN;
			end
			arpc_pkg::ST_SCAN: begin
				if (last_idx) state_d = (cmd_q.op == arpc_pkg::OP_LEARN) ?
					arpc_pkg::ST_WRITE : arpc_pkg::ST_OUT;
			end
			arpc_pkg::ST_WRITE: state_d = arpc_pkg::ST_OUT;
			arpc_pkg::ST_OUT: if (out_ch.ready) state_d = arpc_pkg::ST_IDLE;
			default: state_d = arpc_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpc_pkg::ST_IDLE;
			valid_q <= '0;
			eval_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == arpc_pkg::ST_SCAN);
			if (state_q == arpc_pkg::ST_WRITE) valid_q[wslot] <= 1'b1;
		end
	end

	// entry read, registered ahead of the compare
	always_ff @(posedge clk) begin
		ip_s1    <= ip_mem[rd_idx_q];
		mac_s1   <= mac_mem[rd_idx_q];
		stamp_s1 <= stamp_mem[rd_idx_q];
		vld_s1   <= valid_q[rd_idx_q];
		idx_s1   <= rd_idx_q;
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				cmd_q      <= cmd;
				rd_idx_q   <= '0;
				found_q    <= 1'b0;
				free_q     <= 1'b0;
				best_set_q <= 1'b0;
				best_q     <= '0;
				slot_q     <= '0;
				match_q    <= '0;
				res_q      <= '{dropped: (cmd.op == arpc_pkg::OP_DROP), default: '0};
			end
			arpc_pkg::ST_SCAN: begin
				if (rd_idx_q != LAST) rd_idx_q <= rd_idx_q + 1'b1;
				if (eval_s1) begin
					if (cur_match && !found_q) begin
						found_q <= 1'b1;
						match_q <= idx_s1;
						if (cmd_q.op == arpc_pkg::OP_RESOLVE) res_q.mac_out <= mac_s1;
					end
					if (!free_q) begin
						if (cur_free) begin
							free_q <= 1'b1;
							slot_q <= idx_s1;
						end else if (cur_older) begin
							best_q     <= stamp_s1;
							best_set_q <= 1'b1;
							slot_q     <= idx_s1;
						end
					end
					if (last_idx && cmd_q.op == arpc_pkg::OP_RESOLVE) begin
						res_q.hop_ip       <= cmd_q.ip;
						res_q.hit          <= found_q || cur_match;
						res_q.send_request <= !(found_q || cur_match);
					end
				end
			end
			arpc_pkg::ST_WRITE: begin
				ip_mem[wslot]    <= cmd_q.ip;
				mac_mem[wslot]   <= cmd_q.mac;
				stamp_mem[wslot] <= cmd_q.stamp;
				if (cmd_q.reply) begin
					res_q.send_reply <= 1'b1;
					res_q.mac_out    <= cmd_q.mac;
					res_q.hop_ip     <= cmd_q.ip;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = (state_q == arpc_pkg::ST_OUT);
	assign out_ch.hit          = res_q.hit;
	assign out_ch.mac_out      = res_q.mac_out;
	assign out_ch.hop_ip       = res_q.hop_ip;
	assign out_ch.send_request = res_q.send_request;
	assign out_ch.send_reply   = res_q.send_reply;
	assign out_ch.dropped      = res_q.dropped;

endmodule

@@ src/arp_cache_engine.sv @@
// ----------------------------------------------------------------------------
// arp_cache_engine
// IPv4-to-MAC cache: resolve lookups and ARP learning with reply detection.
// ----------------------------------------------------------------------------
// A front end takes one transaction per cycle, while it has room, into a
// two-deep command queue; the back end scans the cache one entry per cycle
// behind a registered entry read. The entry scan in the back end sets the
// sustained rate. Configuration is always ready.
module arp_cache_engine #(
	parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	arpc_in_if.sink    in_ch,
	arpc_out_if.source out_ch,
	arpc_cfg_if.sink   cfg
);

	logic [31:0] own_ip_q, gateway_q, mask_q;
	logic [47:0] own_mac_q;
	logic           cmd_valid, cmd_ready;
	arpc_pkg::cmd_t cmd;

	assign cfg.ready = 1'b1;

	// configuration registers; own_mac is held but not used by the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= arpc_pkg::OWN_IP_RST;
			gateway_q <= arpc_pkg::GW_RST;
			mask_q    <= arpc_pkg::MASK_RST;
			own_mac_q <= arpc_pkg::OWN_MAC_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				arpc_pkg::REG_OWN_IP:  own_ip_q  <= cfg.data[31:0];
				arpc_pkg::REG_GATEWAY: gateway_q <= cfg.data[31:0];
				arpc_pkg::REG_MASK:    mask_q    <= cfg.data[31:0];
				arpc_pkg::REG_OWN_MAC: own_mac_q <= cfg.data;
				default: ;
			endcase
		end
	end

	arpc_front u_front (
		.clk, .arst_n, .in_ch,
		.own_ip(own_ip_q), .gateway_addr(gateway_q), .subnet_mask(mask_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	arpc_back #(.ENTRIES(ENTRIES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_ch
	);

endmodule

@@ src/arpc_checker.sv @@
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on result transactions of the ARP cache engine.
// ----------------------------------------------------------------------------
module arpc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic hit,
	input logic send_request,
	input logic send_reply,
	input logic dropped,
	input logic [47:0] mac_out
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mac_out))
		else $error("result changed while stalled");

	// at most one outcome flag per result
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({hit, send_request, send_reply, dropped}))
		else $error("conflicting outcome flags");

	// a miss or a drop carries no MAC
	a_nomac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (send_request || dropped) |-> mac_out == '0)
		else $error("MAC on miss or drop");

endmodule

bind arp_cache_engine arpc_checker u_chk (
	.clk, .arst_n,
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.hit(out_ch.hit), .send_request(out_ch.send_request),
	.send_reply(out_ch.send_reply), .dropped(out_ch.dropped),
	.mac_out(out_ch.mac_out)
);

@@ tb/tb_arp_cache_engine.sv @@
// ----------------------------------------------------------------------------
// tb_arp_cache_engine
// Self-checking bench for the ARP cache engine. Drives resolve and ARP packet
// transactions through the input channel, writes the address registers
// between phases, predicts each result with an in-bench copy of the cache
// and compares every output transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_arp_cache_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS      = arpc_pkg::ENTRIES_DEF;
	localparam int POOL_SZ     = 24;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic        func;
		logic [31:0] query_ip;
		logic [15:0] arp_opcode;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [10:0] pkt_len;
		logic [31:0] now_ticks;
	} arp_item_t;

	logic clk;
	logic arst_n;

	arpc_in_if  in_ch();
	arpc_out_if out_ch();
	arpc_cfg_if cfg_ch();

	arp_cache_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// register copies
	logic [31:0] own_ip_r;
	logic [31:0] gw_r;
	logic [31:0] mask_r;
	logic [47:0] own_mac_r;

	// cache copy
	logic        c_valid [NSLOTS];
	logic [31:0] c_ip    [NSLOTS];
	logic [47:0] c_mac   [NSLOTS];
	logic [31:0] c_stamp [NSLOTS];

	logic [31:0] ip_pool [POOL_SZ];

	arpc_pkg::res_t pending_res_q[$];
	int     errors;
	int     cycles = 0;
	bit     calm;         // no idling on either side
	int     rx_wait;
	int     hold_req;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic int cache_find(logic [31:0] ip);
		for (int i = 0; i < NSLOTS; i++)
			if (c_valid[i] && c_ip[i] == ip) return i;
		return -1;
	endfunction

	// expected result for one item; updates the cache copy on learning
	function automatic arpc_pkg::res_t arp_predict(arp_item_t it);
		arpc_pkg::res_t r;
		logic [31:0] hop;
		logic [31:0] best;
		int          slot;
		r = '0;
		if (!it.func) begin
			hop = it.query_ip;
			if ((hop & mask_r) != (own_ip_r & mask_r)) hop = gw_r;
			slot = cache_find(hop);
			r.hop_ip = hop;
			if (slot >= 0) begin
				r.hit = 1'b1;
				r.mac_out = c_mac[slot];
			end else begin
				r.send_request = 1'b1;
			end
		end else if (it.pkt_len < arpc_pkg::MIN_PKT_LEN) begin
			r.dropped = 1'b1;
		end else begin
			slot = cache_find(it.src_ip);
			if (slot < 0) begin
				best = '1;
				slot = 0;
				for (int i = 0; i < NSLOTS; i++) begin
					if (!c_valid[i]) begin
						slot = i;
						break;
					end
					if (c_stamp[i] < best) begin
						best = c_stamp[i];
						slot = i;
					end
				end
				c_ip[slot] = it.src_ip;
				c_valid[slot] = 1'b1;
			end
			c_mac[slot] = it.src_mac;
			c_stamp[slot] = it.now_ticks;
			if (it.arp_opcode == arpc_pkg::OP_REQUEST && it.dst_ip == own_ip_r) begin
				r.send_reply = 1'b1;
				r.mac_out = it.src_mac;
				r.hop_ip = it.src_ip;
			end
		end
		return r;
	endfunction

	// addresses inside the current subnet, plus the gateway
	function automatic void refill_pool();
		for (int i = 0; i < POOL_SZ; i++)
			ip_pool[i] = (own_ip_r & mask_r) | ($urandom() & ~mask_r);
		ip_pool[0] = gw_r;
		ip_pool[1] = own_ip_r;
	endfunction

	function automatic logic [31:0] pick_ip();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return ip_pool[$urandom_range(0, POOL_SZ - 1)];
		endcase
	endfunction

	function automatic arp_item_t rand_item();
		arp_item_t it;
		it.func       = 1'($urandom_range(0, 1));
		it.query_ip   = pick_ip();
		it.src_ip     = pick_ip();
		it.dst_ip     = $urandom_range(0, 2) ? own_ip_r : pick_ip();
		it.arp_opcode = $urandom_range(0, 2) ? arpc_pkg::OP_REQUEST : 16'($urandom());
		it.src_mac    = {16'($urandom()), 32'($urandom())};
		case ($urandom_range(0, 9))
			0: it.pkt_len = 11'($urandom_range(0, 27));
			1: it.pkt_len = 11'($urandom());
			default: it.pkt_len = 11'($urandom_range(28, 64));
		endcase
		case ($urandom_range(0, 3))
			0: it.now_ticks = $urandom();
			1: it.now_ticks = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: it.now_ticks = $urandom_range(0, 7);
		endcase
		return it;
	endfunction

	function automatic arp_item_t mk_item(logic f, logic [31:0] q, logic [15:0] op,
			logic [47:0] smac, logic [31:0] sip, logic [31:0] tip, logic [10:0] len,
			logic [31:0] ts);
		arp_item_t it;
		it.func = f; it.query_ip = q; it.arp_opcode = op; it.src_mac = smac;
		it.src_ip = sip; it.dst_ip = tip; it.pkt_len = len; it.now_ticks = ts;
		return it;
	endfunction

	// send one transaction; valid stays high when the next follows at once
	task automatic send_item(arp_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.func       = it.func;
		in_ch.query_ip   = it.query_ip;
		in_ch.arp_opcode = it.arp_opcode;
		in_ch.src_mac    = it.src_mac;
		in_ch.src_ip     = it.src_ip;
		in_ch.dst_ip     = it.dst_ip;
		in_ch.pkt_len    = it.pkt_len;
		in_ch.now_ticks  = it.now_ticks;
		in_ch.valid      = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_res_q.push_back(arp_predict(it));
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending_res_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			arpc_pkg::REG_OWN_IP:  own_ip_r  = val[31:0];
			arpc_pkg::REG_GATEWAY: gw_r      = val[31:0];
			arpc_pkg::REG_MASK:    mask_r    = val[31:0];
			arpc_pkg::REG_OWN_MAC: own_mac_r = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_regs(logic [31:0] ip, logic [31:0] gw, logic [31:0] msk,
			logic [47:0] mac);
		drain();
		write_reg(arpc_pkg::REG_OWN_IP, {16'h0, ip});
		write_reg(arpc_pkg::REG_GATEWAY, {16'h0, gw});
		write_reg(arpc_pkg::REG_MASK, {16'h0, msk});
		write_reg(arpc_pkg::REG_OWN_MAC, mac);
		refill_pool();
	endtask

	// receiver: per-transaction stall, plus a long hold on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready = 1'b0;
		end else if (hold_req > 0) begin
			out_ch.ready = 1'b0;
			hold_req = hold_req - 1;
		end else if (rx_wait > 0) begin
			out_ch.ready = 1'b0;
			rx_wait = rx_wait - 1;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		arpc_pkg::res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			rx_wait = draw_gap();
			if (pending_res_q.size() == 0) begin
				$display("%0t: unexpected result transaction", $realtime);
				errors++;
			end else begin
				e = pending_res_q.pop_front();
				if (out_ch.hit !== e.hit) begin
					$display("%0t: hit exp %0h got %0h", $realtime, e.hit, out_ch.hit);
					errors++;
				end
				if (out_ch.mac_out !== e.mac_out) begin
					$display("%0t: mac_out exp %h got %h", $realtime, e.mac_out,
						out_ch.mac_out);
					errors++;
				end
				if (out_ch.hop_ip !== e.hop_ip) begin
					$display("%0t: hop_ip exp %h got %h", $realtime, e.hop_ip,
						out_ch.hop_ip);
					errors++;
				end
				if (out_ch.send_request !== e.send_request) begin
					$display("%0t: send_request exp %0h got %0h", $realtime,
						e.send_request, out_ch.send_request);
					errors++;
				end
				if (out_ch.send_reply !== e.send_reply) begin
					$display("%0t: send_reply exp %0h got %0h", $realtime,
						e.send_reply, out_ch.send_reply);
					errors++;
				end
				if (out_ch.dropped !== e.dropped) begin
					$display("%0t: dropped exp %0h got %0h", $realtime, e.dropped,
						out_ch.dropped);
					errors++;
				end
			end
		end
	end

	// corner cases with reset register values
	task automatic test_directed();
		calm = 1'b0;
		// misses on an empty cache: local and off-subnet
		send_item(mk_item(1'b0, 32'h0A00_0005, '0, '0, '0, '0, '0, '0));
		send_item(mk_item(1'b0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0));
		send_item(mk_item(1'b0, 32'h0, '0, '0, '0, '0, '0, '0));
		// short packets
		send_item(mk_item(1'b1, '0, arpc_pkg::OP_REQUEST, '1, 32'h0A00_0005, own_ip_r,
			11'd0, '0));
		send_item(mk_item(1'b1, '0, arpc_pkg::OP_REQUEST, '1, 32'h0A00_0005, own_ip_r,
			11'd27, '0));
		// minimal learn, request for us
		send_item(mk_item(1'b1, '0, arpc_pkg::OP_REQUEST, 48'h0011_2233_4455,
			32'h0A00_0005, own_ip_r, 11'd28, 32'd10));
		send_item(mk_item(1'b0, 32'h0A00_0005, '0, '0, '0, '0, '0, '0));
		// refresh same ip, opcode other than request
		send_item(mk_item(1'b1, '0, 16'hFFFF, '1, 32'h0A00_0005, own_ip_r, 11'h7FF,
			32'hFFFF_FFFF));
		send_item(mk_item(1'b0, 32'h0A00_0005, '0, '0, '0, '0, '0, '0));
		// request not for us; learn the gateway
		send_item(mk_item(1'b1, '0, arpc_pkg::OP_REQUEST, 48'hAAAA_5555_AAAA, gw_r,
			32'h0A00_0009, 11'd60, 32'd0));
		send_item(mk_item(1'b0, 32'hC0A8_0101, '0, '0, '0, '0, '0, '0));
		// fill all slots then evict the smallest stamp
		for (int i = 0; i < NSLOTS; i++)
			send_item(mk_item(1'b1, '1, 16'd2, {16'hBEEF, 32'(i)},
				32'h0A00_0100 + 32'(i), '1, 11'd28, 32'd100 + 32'(i)));
		send_item(mk_item(1'b0, gw_r, '0, '0, '0, '0, '0, '0));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
			send_item(rand_item());
		end
	endtask

	// receiver holds off long enough for the input to back up
	task automatic test_backpressure();
		calm = 1'b1;
		hold_req = 300;
		for (int i = 0; i < 20; i++) send_item(rand_item());
		calm = 1'b0;
	endtask

	task automatic test_config_phases();
		set_regs(32'h0, 32'h0, 32'h0, 48'h0);
		test_random(150);
		set_regs('1, '1, '1, '1);
		test_random(150);
		set_regs(32'hC0A8_0001, 32'h0, 32'hFFFF_0000, 48'h0102_0304_0506);
		test_random(200);
		set_regs($urandom(), $urandom(), 32'hFFFF_FFF0, {16'($urandom()), 32'($urandom())});
		test_random(200);
		set_regs(arpc_pkg::OWN_IP_RST, arpc_pkg::GW_RST, arpc_pkg::MASK_RST,
			arpc_pkg::OWN_MAC_RST);
		test_random(150);
	endtask

	initial begin
		errors = 0;
		calm = 1'b0;
		rx_wait = 0;
		hold_req = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.query_ip = '0;
		in_ch.arp_opcode = '0;
		in_ch.src_mac = '0;
		in_ch.src_ip = '0;
		in_ch.dst_ip = '0;
		in_ch.pkt_len = '0;
		in_ch.now_ticks = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = arpc_pkg::REG_OWN_IP;
		cfg_ch.data = '0;
		own_ip_r = arpc_pkg::OWN_IP_RST;
		gw_r = arpc_pkg::GW_RST;
		mask_r = arpc_pkg::MASK_RST;
		own_mac_r = arpc_pkg::OWN_MAC_RST;
		for (int i = 0; i < NSLOTS; i++) begin
			c_valid[i] = 1'b0;
			c_ip[i] = '0;
			c_mac[i] = '0;
			c_stamp[i] = '0;
		end
		refill_pool();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(400);
		test_backpressure();
		test_config_phases();
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/arpc_pkg.sv
src/arpc_if.sv
src/arpc_front.sv
src/arpc_back.sv
src/arp_cache_engine.sv
src/arpc_checker.sv
tb/tb_arp_cache_engine.sv
